FILE: sv/ats_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg: shared definitions of the alarm-tone sequencer
// Queue sizing, signal codes, play phases, command format and the beep tables.
// ----------------------------------------------------------------------------
package ats_pkg;

   // Ring queue of signal codes
   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

   // Command queue between the front and the back
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
   localparam int CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

   localparam int CODE_W   = 3;
   localparam int BEEP_W   = 4;
   localparam int MS_W     = 10;
   localparam int PERIOD_W = 11;

   localparam logic [MS_W-1:0] GAP_MS          = 10'd100;
   localparam logic [MS_W-1:0] END_PAUSE_RESET = 10'd500;

   // Tone timer reload values
   localparam int TONE_CLOCK = 500000;
   localparam logic [PERIOD_W-1:0] PERIOD_300HZ  = PERIOD_W'(TONE_CLOCK / 300);
   localparam logic [PERIOD_W-1:0] PERIOD_500HZ  = PERIOD_W'(TONE_CLOCK / 500);
   localparam logic [PERIOD_W-1:0] PERIOD_700HZ  = PERIOD_W'(TONE_CLOCK / 700);
   localparam logic [PERIOD_W-1:0] PERIOD_1000HZ = PERIOD_W'(TONE_CLOCK / 1000);
   localparam logic [PERIOD_W-1:0] PERIOD_1500HZ = PERIOD_W'(TONE_CLOCK / 1500);
   localparam logic [PERIOD_W-1:0] PERIOD_2000HZ = PERIOD_W'(TONE_CLOCK / 2000);

   // Signal codes
   localparam logic [CODE_W-1:0] CODE_NONE      = 3'd0;
   localparam logic [CODE_W-1:0] CODE_STARTUP   = 3'd1;
   localparam logic [CODE_W-1:0] CODE_LOW_BATT  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_CRIT_BATT = 3'd3;
   localparam logic [CODE_W-1:0] CODE_BUCK1_ERR = 3'd4;
   localparam logic [CODE_W-1:0] CODE_BUCK2_ERR = 3'd5;
   localparam logic [CODE_W-1:0] CODE_NO_RA     = 3'd6;
   localparam logic [CODE_W-1:0] CODE_NO_DEC    = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_TONE  = 4'b0010,
      PH_GAP   = 4'b0100,
      PH_PAUSE = 4'b1000
   } phase_type;

   typedef enum logic [0:0] {
      CMD_TICK    = 1'b0,
      CMD_ENQUEUE = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CODE_W-1:0] code;
   } cmd_type;

   function automatic logic [QIDX_W-1:0] queue_idx_next(input logic [QIDX_W-1:0] idx);
      if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   function automatic logic [BEEP_W-1:0] beep_count(input logic [CODE_W-1:0] code);
      logic [BEEP_W-1:0] n;
      case (code) inside
         CODE_STARTUP, CODE_LOW_BATT, CODE_BUCK1_ERR, CODE_BUCK2_ERR: n = 4'd5;
         CODE_CRIT_BATT:                                              n = 4'd10;
         CODE_NO_RA, CODE_NO_DEC:                                     n = 4'd3;
         default:                                                     n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [MS_W-1:0] beep_on_ms(input logic [CODE_W-1:0] code,
                                                  input logic [BEEP_W-1:0] beep);
      logic [MS_W-1:0] ms;
      case (code) inside
         CODE_STARTUP:                       ms = (beep == 4'd3) ? 10'd300 : 10'd100;
         CODE_LOW_BATT, CODE_NO_RA, CODE_NO_DEC: ms = 10'd100;
         CODE_CRIT_BATT:                     ms = 10'd300;
         CODE_BUCK1_ERR, CODE_BUCK2_ERR:     ms = 10'd50;
         default:                            ms = '0;
      endcase
      return ms;
   endfunction

   function automatic logic [PERIOD_W-1:0] beep_period(input logic [CODE_W-1:0] code,
                                                       input logic [BEEP_W-1:0] beep);
      logic [PERIOD_W-1:0] p;
      case (code) inside
         CODE_STARTUP: begin
            case (beep) inside
               4'd0:       p = PERIOD_300HZ;
               4'd1:       p = PERIOD_500HZ;
               4'd2, 4'd4: p = PERIOD_700HZ;
               default:    p = PERIOD_1000HZ;
            endcase
         end
         CODE_LOW_BATT, CODE_CRIT_BATT: p = PERIOD_1000HZ;
         CODE_BUCK1_ERR: p = (beep == 4'd2) ? PERIOD_500HZ : PERIOD_1000HZ;
         CODE_BUCK2_ERR: p = (beep == 4'd2) ? PERIOD_1500HZ : PERIOD_1000HZ;
         CODE_NO_RA:     p = PERIOD_1500HZ;
         CODE_NO_DEC:    p = PERIOD_2000HZ;
         default:        p = '0;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

FILE: sv/ats_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_front: request intake and command queue
// Accepts request transactions, classifies them as tick or enqueue and holds
// them in a short queue until the sequencer takes them.
// ----------------------------------------------------------------------------
module ats_front
   import ats_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic [0:0]        req_tuser,
   output      logic              cmd_valid,
   output      cmd_type           cmd_head,
   input  wire logic              cmd_pop
);

   cmd_type                cmd_q_ff [CMD_QUEUE_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   push;
   logic                   pop;
   cmd_type                cmd_new;

   assign req_tready = (cnt_ff != CMD_CNT_W'(CMD_QUEUE_DEPTH));
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd_head   = cmd_q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_pop && cmd_valid;

   // Classify: a tick carries no code
   always_comb begin
      cmd_new.kind = req_tuser[0] ? CMD_ENQUEUE : CMD_TICK;
      cmd_new.code = req_tuser[0] ? req_tdata[CODE_W-1:0] : CODE_NONE;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ats_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_back: code queue, beep sequencer and response register
// One command per cycle unless the response stalls; tone state is registered.
// ----------------------------------------------------------------------------
module ats_back
   import ats_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire cmd_type           cmd_head,
   output      logic              cmd_pop,
   input  wire logic              csr_wr_en,
   input  wire logic [MS_W-1:0]   csr_wr_data,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [15:0]       rsp_tdata
);

   logic [CODE_W-1:0]   code_store_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CODE_W-1:0]   active_ff, active_in;
   logic [BEEP_W-1:0]   beep_ff, beep_in;
   phase_type           phase_ff, phase_in;
   logic [MS_W-1:0]     ms_ff, ms_in;
   logic [MS_W-1:0]     end_pause_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;

   logic                take;
   logic                store_we;
   logic [CODE_W-1:0]   pop_code;
   logic [MS_W-1:0]     ms_dec;
   logic [BEEP_W-1:0]   beep_next;
   logic                tone_on;
   logic [PERIOD_W-1:0] tone_period;

   assign take      = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign cmd_pop   = take;
   assign pop_code  = code_store_ff[rd_idx_ff];
   assign ms_dec    = (ms_ff == '0) ? '0 : ms_ff - 1'b1;
   assign beep_next = beep_ff + 1'b1;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      active_in = active_ff;
      beep_in   = beep_ff;
      phase_in  = phase_ff;
      ms_in     = ms_ff;
      store_we  = 1'b0;
      if (take) begin
         if (cmd_head.kind == CMD_ENQUEUE) begin
            store_we  = 1'b1;
            wr_idx_in = queue_idx_next(wr_idx_ff);
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (rd_idx_ff != wr_idx_ff) begin
                     rd_idx_in = queue_idx_next(rd_idx_ff);
                     if (pop_code != CODE_NONE) begin
                        active_in = pop_code;
                        beep_in   = '0;
                        phase_in  = PH_TONE;
                        ms_in     = beep_on_ms(pop_code, '0);
                     end
                  end
               end
               PH_TONE: begin
                  ms_in = ms_dec;
                  if (ms_dec == '0) begin
                     phase_in = PH_GAP;
                     ms_in    = GAP_MS;
                  end
               end
               PH_GAP: begin
                  ms_in = ms_dec;
                  if (ms_dec == '0) begin
                     beep_in = beep_next;
                     if (beep_next < beep_count(active_ff)) begin
                        phase_in = PH_TONE;
                        ms_in    = beep_on_ms(active_ff, beep_next);
                     end else if (end_pause_ff != '0) begin
                        phase_in = PH_PAUSE;
                        ms_in    = end_pause_ff;
                     end else begin
                        phase_in = PH_IDLE;
                        ms_in    = '0;
                     end
                  end
               end
               PH_PAUSE: begin
                  ms_in = ms_dec;
                  if (ms_dec == '0) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Response reflects the state after the command
   always_comb begin
      tone_on     = (phase_in == PH_TONE);
      tone_period = tone_on ? beep_period(active_in, beep_in) : '0;
      rsp_data_in = {3'b000, (phase_in != PH_IDLE), tone_period, tone_on};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         active_ff    <= CODE_NONE;
         beep_ff      <= '0;
         phase_ff     <= PH_IDLE;
         ms_ff        <= '0;
         end_pause_ff <= END_PAUSE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         active_ff    <= active_in;
         beep_ff      <= beep_in;
         phase_ff     <= phase_in;
         ms_ff        <= ms_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            end_pause_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         code_store_ff[wr_idx_ff] <= cmd_head.code;
      end
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: sv/alarm_tone_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_tone_sequencer: buzzer pattern sequencer with a queue of signal codes
// Top level: request intake, command queue and the beep sequencer.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one response transaction that shows
// the tone state after that request. A request with tuser set enqueues a
// 3-bit signal code into a 16-entry ring queue (no full check: wrapping onto
// the read pointer empties the queue); a request with tuser clear is one
// millisecond tick. On a tick that finds the sequencer idle with codes waiting,
// one code is popped and, if it is nonzero, its beep list starts; each beep
// sounds for its on-time, then stays silent for 100 ms, and every nonzero code
// ends with end_pause_ms silent ticks (written through csr_wr_en/csr_wr_data,
// reset 500, write only while no request is outstanding). The block takes one
// request per clock while the command queue has room, a rate set by the
// sequencer, which applies one command per cycle while its response is not
// stalled. Each request passes through the command queue and the sequencer's
// response register before rsp_tvalid rises. A four-entry command queue
// between intake and sequencer absorbs response back-pressure; req_tready
// drops only when that queue is full. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module alarm_tone_sequencer
   import ats_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   // Request channel
   input  wire logic            req_tvalid,
   output      logic            req_tready,
   input  wire logic [7:0]      req_tdata,   // [2:0] signal_code, [7:3] zero
   input  wire logic [0:0]      req_tuser,   // [0] mode: 0 tick, 1 enqueue
   // Response channel
   output      logic            rsp_tvalid,
   input  wire logic            rsp_tready,
   output      logic [15:0]     rsp_tdata,   // [0] tone_on, [11:1] tone_period,
                                             // [12] busy_res, [15:13] zero
   // Configuration: end_pause_ms
   input  wire logic            csr_wr_en,
   input  wire logic [MS_W-1:0] csr_wr_data
);

   logic    cmd_valid;
   cmd_type cmd_head;
   logic    cmd_pop;

   // Intake: classify each transaction and hold it until the sequencer is free
   ats_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop)
   );

   // Sequencer: advance the code queue and beep phases, hold the response
   ats_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: sv/ats_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_checker: port-level checks of the alarm-tone sequencer
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ats_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // No response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Silent response carries no period
   a_silent_period: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[11:1] == 11'd0))
      else $error("period set while tone off");

   // Sounding tone has a period and the sequencer is busy
   a_tone_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[12] && (rsp_tdata[11:1] != 11'd0)))
      else $error("tone on without busy or period");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind alarm_tone_sequencer ats_checker u_ats_checker (.*);
`default_nettype wire
